// ----- src/gda_pkg.sv -----
// Types, constants and calendar helper functions for the Gregorian date block.
package gda_pkg;

    localparam int unsigned SER_W       = 22;
    localparam int unsigned YEAR_MAX    = 9999;
    localparam int unsigned LAST_SERIAL = 3652059;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_BAD_DATE    = 2'd1;
    localparam logic [1:0] STAT_LATER_OOR   = 2'd2;
    localparam logic [1:0] STAT_EARLIER_OOR = 2'd3;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [19:0] offset;
    } t_in_item;

    typedef struct packed {
        logic        leap;
        logic [8:0]  day_of_year;
        logic [21:0] day_number;
        logic [4:0]  later_day;
        logic [3:0]  later_month;
        logic [13:0] later_year;
        logic [4:0]  earlier_day;
        logic [3:0]  earlier_month;
        logic [13:0] earlier_year;
        logic [1:0]  status;
    } t_result;

    function automatic logic [4:0] f_month_days(logic [3:0] m, logic leap);
        logic [4:0] d;
        case (m)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // Divisor per level: date to serial splits years, serial to date splits days.
    function automatic logic [SER_W-1:0] f_divisor(logic rev, logic [1:0] lvl);
        logic [SER_W-1:0] v;
        case (lvl)
            2'd0:    v = rev ? SER_W'(146097) : SER_W'(400);
            2'd1:    v = rev ? SER_W'(36524)  : SER_W'(100);
            2'd2:    v = rev ? SER_W'(1461)   : SER_W'(4);
            default: v = rev ? SER_W'(365)    : SER_W'(1);
        endcase
        return v;
    endfunction

    // Weight added to the accumulator for each unit of quotient.
    function automatic logic [SER_W-1:0] f_addend(logic rev, logic [1:0] lvl);
        logic [SER_W-1:0] v;
        case (lvl)
            2'd0:    v = rev ? SER_W'(400) : SER_W'(146097);
            2'd1:    v = rev ? SER_W'(100) : SER_W'(36524);
            2'd2:    v = rev ? SER_W'(4)   : SER_W'(1461);
            default: v = rev ? SER_W'(1)   : SER_W'(365);
        endcase
        return v;
    endfunction

    // Top quotient bit per level: 400-year and 4-year counts take 5 bits, the others 2.
    function automatic logic [2:0] f_level_msb(logic [1:0] lvl);
        return lvl[0] ? 3'd1 : 3'd4;
    endfunction

endpackage

// ----- src/gregorian_date_arithmetic.sv -----
// Top level: iterative Gregorian date to serial day number and date offset unit.
//
// One item is taken when start is high and busy is low; the result appears on
// o_result for exactly one cycle with o_valid high and cannot be held off.
// An item with a bad year, a bad month or a zero day strobes in the cycle
// after the accepting edge. A day past the end of its month strobes once the
// forward month walk reaches its month. A valid date strobes after S_SER and the
// later and earlier conversions that are in range, each with S_NEXT. busy falls the
// cycle after the strobe. The work is done by one shared compare-and-subtract
// step that produces one quotient bit per cycle (14 quotient bits per conversion,
// up to three conversions: date to serial, serial plus offset and serial minus
// offset to date) and by a month walk after each one.
module gregorian_date_arithmetic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  gda_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_valid,
    output gda_pkg::t_result  o_result
);
    import gda_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MON  = 6'b000100,
        S_SER  = 6'b001000,
        S_NEXT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_LATER,
        PH_EARLIER
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [4:0]       r_day;
    logic [3:0]       r_month;
    logic [19:0]      r_offset;
    logic [SER_W-1:0] r_rem, n_rem;
    logic [SER_W-1:0] r_acc, n_acc;
    logic [1:0]       r_lvl, n_lvl;
    logic [2:0]       r_k, n_k;
    logic [4:0]       r_q, n_q;
    logic [1:0]       r_q100, n_q100;
    logic [4:0]       r_q4, n_q4;
    logic             r_leap, n_leap;
    logic [3:0]       r_mon, n_mon;
    logic [8:0]       r_doy, n_doy;
    logic [SER_W-1:0] r_serial, n_serial;
    t_result          r_res, n_res;

    logic             w_rev;
    logic [SER_W-1:0] w_div_sh;
    logic [SER_W-1:0] w_add_sh;
    logic [SER_W:0]   w_diff;
    logic             w_ge;
    logic [4:0]       w_q_next;
    logic [4:0]       w_mdays;
    logic [SER_W:0]   w_sum_later;
    logic [8:0]       w_doy;
    logic             w_coarse_bad;

    // Shared step: compare remainder against the shifted divisor, subtract on hit.
    assign w_rev       = (r_phase != PH_FWD);
    assign w_div_sh    = f_divisor(w_rev, r_lvl) << r_k;
    assign w_add_sh    = f_addend(w_rev, r_lvl) << r_k;
    assign w_diff      = {1'b0, r_rem} - {1'b0, w_div_sh};
    assign w_ge        = ~w_diff[SER_W];
    assign w_q_next    = {r_q[3:0], w_ge};
    assign w_mdays     = f_month_days(r_mon, r_leap);
    assign w_sum_later = {1'b0, r_serial} + (SER_W+1)'(r_offset);
    assign w_doy       = r_rem[8:0] + 9'(r_day);
    assign w_coarse_bad = (i_item.year == 14'd0) || (i_item.year > 14'(YEAR_MAX)) ||
                          (i_item.month == 4'd0) || (i_item.month > 4'd12) ||
                          (i_item.day == 5'd0);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_lvl    = r_lvl;
        n_k      = r_k;
        n_q      = r_q;
        n_q100   = r_q100;
        n_q4     = r_q4;
        n_leap   = r_leap;
        n_mon    = r_mon;
        n_doy    = r_doy;
        n_serial = r_serial;
        n_res    = r_res;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res   = '0;
                    n_phase = PH_FWD;
                    if (w_coarse_bad) begin
                        n_res.status = STAT_BAD_DATE;
                        n_state      = S_DONE;
                    end else begin
                        n_rem   = SER_W'(i_item.year) - SER_W'(1);
                        n_acc   = '0;
                        n_lvl   = 2'd0;
                        n_k     = f_level_msb(2'd0);
                        n_q     = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_ge) begin
                    n_rem = w_diff[SER_W-1:0];
                    n_acc = r_acc + w_add_sh;
                end
                n_q = w_q_next;
                if (r_k == 3'd0) begin
                    case (r_lvl)
                        2'd1:    n_q100 = w_q_next[1:0];
                        2'd2:    n_q4   = w_q_next;
                        default: ;
                    endcase
                    if (r_lvl == 2'd3) begin
                        // year-1 = 400a + 100b + 4c + d: leap when d is 3,
                        // unless c is 24 and b is not 3
                        n_leap  = (w_q_next[1:0] == 2'd3) &&
                                  ((r_q4 != 5'd24) || (r_q100 == 2'd3));
                        n_mon   = 4'd1;
                        n_state = S_MON;
                    end else begin
                        n_lvl = r_lvl + 2'd1;
                        n_k   = f_level_msb(r_lvl + 2'd1);
                        n_q   = '0;
                    end
                end else begin
                    n_k = r_k - 3'd1;
                end
            end
            S_MON: begin
                if (r_phase == PH_FWD) begin
                    if (r_mon < r_month) begin
                        n_rem = r_rem + SER_W'(w_mdays);
                        n_mon = r_mon + 4'd1;
                    end else if (r_day > w_mdays) begin
                        n_res        = '0;
                        n_res.status = STAT_BAD_DATE;
                        n_state      = S_DONE;
                    end else begin
                        n_doy   = w_doy;
                        n_state = S_SER;
                    end
                end else begin
                    if ((r_mon < 4'd12) && (r_rem >= SER_W'(w_mdays))) begin
                        n_rem = r_rem - SER_W'(w_mdays);
                        n_mon = r_mon + 4'd1;
                    end else begin
                        if (r_phase == PH_LATER) begin
                            n_res.later_day   = r_rem[4:0] + 5'd1;
                            n_res.later_month = r_mon;
                            n_res.later_year  = r_acc[13:0] + 14'd1;
                        end else begin
                            n_res.earlier_day   = r_rem[4:0] + 5'd1;
                            n_res.earlier_month = r_mon;
                            n_res.earlier_year  = r_acc[13:0] + 14'd1;
                        end
                        n_state = S_NEXT;
                    end
                end
            end
            S_SER: begin
                n_serial          = r_acc + SER_W'(r_doy);
                n_res.leap        = r_leap;
                n_res.day_of_year = r_doy;
                n_res.day_number  = r_acc + SER_W'(r_doy);
                n_state           = S_NEXT;
            end
            S_NEXT: begin
                n_acc = '0;
                n_lvl = 2'd0;
                n_k   = f_level_msb(2'd0);
                n_q   = '0;
                case (r_phase)
                    PH_FWD: begin
                        n_phase = PH_LATER;
                        if (w_sum_later > (SER_W+1)'(LAST_SERIAL)) begin
                            // hold here and take the earlier date next cycle
                            n_res.status = STAT_LATER_OOR;
                        end else begin
                            n_rem   = w_sum_later[SER_W-1:0] - SER_W'(1);
                            n_state = S_DIV;
                        end
                    end
                    PH_LATER: begin
                        n_phase = PH_EARLIER;
                        if (SER_W'(r_offset) >= r_serial) begin
                            n_res.status = STAT_EARLIER_OOR;
                            n_state      = S_DONE;
                        end else begin
                            n_rem   = r_serial - SER_W'(r_offset) - SER_W'(1);
                            n_state = S_DIV;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FWD;
            r_lvl   <= 2'd0;
            r_k     <= 3'd0;
            r_mon   <= 4'd1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_lvl   <= n_lvl;
            r_k     <= n_k;
            r_mon   <= n_mon;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_q      <= n_q;
        r_q100   <= n_q100;
        r_q4     <= n_q4;
        r_leap   <= n_leap;
        r_doy    <= n_doy;
        r_serial <= n_serial;
        r_res    <= n_res;
        if ((r_state == S_IDLE) && start) begin
            r_day    <= i_item.day;
            r_month  <= i_item.month;
            r_offset <= i_item.offset;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_result = r_res;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STAT_BAD_DATE)) |->
        (!o_result.leap && (o_result.day_number == '0) &&
         (o_result.later_year == '0) && (o_result.earlier_year == '0)))
        else $error("invalid date result carries nonzero fields");

    a_ok_dates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STAT_OK)) |->
        ((o_result.later_month != '0) && (o_result.earlier_month != '0) &&
         (o_result.later_year != '0) && (o_result.earlier_year != '0)))
        else $error("in-range result is missing a date");

    a_later_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STAT_LATER_OOR)) |->
        ((o_result.later_year == '0) && (o_result.earlier_year != '0)))
        else $error("later out of range with inconsistent date fields");

endmodule
